FILE: hdl/tga_pkg.sv
// Shared types and constants for the TGA run-length pixel decoder.
// No dependencies; every other file of the block depends on this package.
`timescale 1ns / 1ps
`default_nettype none

package tga_pkg;

    // Field widths of the stream, the decoded pixel and the register port
    localparam int BYTE_W   = 8;
    localparam int CHAN_W   = 3;
    localparam int TOTAL_W  = 32;
    localparam int CFG_IDX_W = 4;

    // Packet header coding
    localparam int            RUN_FLAG_BIT = 7;
    localparam logic [7:0]    RUN_BIAS     = 8'd127;
    localparam logic [CHAN_W-1:0] CHAN_BGRA = 3'd4;

    // Register indexes on the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CHANNELS = 4'd0,
        REG_TOTAL    = 4'd1
    } cfg_reg_t;

    // Configuration as seen by the decoding core
    typedef struct packed {
        logic [CHAN_W-1:0]  channels;
        logic [TOTAL_W-1:0] total_pixels;
    } cfg_t;

    // One decoded pixel
    typedef struct packed {
        logic [BYTE_W-1:0] red;
        logic [BYTE_W-1:0] green;
        logic [BYTE_W-1:0] blue;
        logic [BYTE_W-1:0] alpha;
        logic [BYTE_W-1:0] repeat_res;
        logic              image_done;
    } pixel_t;

endpackage

`default_nettype wire

FILE: hdl/tga_ifs.sv
// Valid/ready channel interfaces of the TGA run-length pixel decoder.
// Depends on tga_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

// Coded stream, one byte per item
interface tga_byte_if;
    logic                      valid;
    logic                      ready;
    logic [tga_pkg::BYTE_W-1:0] stream_byte;

    modport source (output valid, output stream_byte, input ready);
    modport sink   (input valid, input stream_byte, output ready);
endinterface

// Decoded pixels, one pixel and its repeat count per item
interface tga_pix_if;
    logic                      valid;
    logic                      ready;
    logic [tga_pkg::BYTE_W-1:0] red;
    logic [tga_pkg::BYTE_W-1:0] green;
    logic [tga_pkg::BYTE_W-1:0] blue;
    logic [tga_pkg::BYTE_W-1:0] alpha;
    logic [tga_pkg::BYTE_W-1:0] repeat_res;
    logic                      image_done;

    modport source (output valid, output red, output green, output blue,
                    output alpha, output repeat_res, output image_done,
                    input ready);
    modport sink   (input valid, input red, input green, input blue,
                    input alpha, input repeat_res, input image_done,
                    output ready);
endinterface

// Register writes
interface tga_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [tga_pkg::CFG_IDX_W-1:0] index;
    logic [tga_pkg::TOTAL_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: hdl/tga_rle_pixel_decoder.sv
// Top level of the TGA run-length pixel decoder: register port, input
// register and the decoding core. Depends on tga_pkg, tga_ifs and tga_core.
//
//  Port     Dir   Carries
//  stream   in    stream_byte: one byte of the coded pixel stream per item
//  pixel    out   red, green, blue, alpha, repeat_res, image_done
//  cfg      in    index 0 channels, index 1 total_pixels; always ready
//
// One byte is taken in every cycle while no completing byte is held back; a
// pixel passes the input register, then the result register of the core.
// The per-byte packet and pixel-count update is the only work on a byte.
// A byte that completes a pixel waits in the input register while a pixel
// is still held unread; header and other bytes pass on regardless.
// Reset clears all decoding state; the registers return to channels 3 and
// total_pixels 1.
`timescale 1ns / 1ps
`default_nettype none

module tga_rle_pixel_decoder (
    input  wire logic clk,
    input  wire logic rst_n,
    tga_byte_if.sink  stream,
    tga_pix_if.source pixel,
    tga_cfg_if.sink   cfg
);
    import tga_pkg::*;

    logic              stage_valid_reg;
    logic [BYTE_W-1:0] stage_byte_reg;
    cfg_t              cfg_reg;
    logic              take;
    pixel_t            res;
    logic              res_valid;

    // Register writes
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.channels     <= CHAN_W'(3);
            cfg_reg.total_pixels <= TOTAL_W'(1);
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_CHANNELS: cfg_reg.channels     <= cfg.data[CHAN_W-1:0];
                REG_TOTAL:    cfg_reg.total_pixels <= cfg.data;
                default:      ;
            endcase
        end
    end

    // Input register; refills in the cycle it drains
    assign stream.ready = !stage_valid_reg || take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_valid_reg <= 1'b0;
        else if (stream.valid && stream.ready)
            stage_valid_reg <= 1'b1;
        else if (take)
            stage_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (stream.valid && stream.ready)
            stage_byte_reg <= stream.stream_byte;
    end

    // Decoding core
    tga_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .byte_valid (stage_valid_reg),
        .byte_data  (stage_byte_reg),
        .byte_take  (take),
        .res_valid  (res_valid),
        .res        (res),
        .res_ready  (pixel.ready)
    );

    assign pixel.valid      = res_valid;
    assign pixel.red        = res.red;
    assign pixel.green      = res.green;
    assign pixel.blue       = res.blue;
    assign pixel.alpha      = res.alpha;
    assign pixel.repeat_res = res.repeat_res;
    assign pixel.image_done = res.image_done;

endmodule

`default_nettype wire

FILE: hdl/tga_core.sv
// Decoding core: packet and pixel state, per-byte update and result register.
// Depends on tga_pkg for the configuration and pixel types.
`timescale 1ns / 1ps
`default_nettype none

module tga_core (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire tga_pkg::cfg_t              cfg,
    input  wire logic                       byte_valid,
    input  wire logic [tga_pkg::BYTE_W-1:0] byte_data,
    output logic                            byte_take,
    output logic                            res_valid,
    output tga_pkg::pixel_t                 res,
    input  wire logic                       res_ready
);
    import tga_pkg::*;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_PIXEL  = 2'd1
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic [7:0]         remain_reg, remain_next;
    logic               run_reg, run_next;
    logic [1:0]         idx_reg, idx_next;
    logic [BYTE_W-1:0]  colour_reg [3];
    logic [BYTE_W-1:0]  colour_next [3];
    logic [TOTAL_W-1:0] done_cnt_reg, done_cnt_next;
    logic               res_valid_reg;
    pixel_t             res_reg, res_next;

    logic [TOTAL_W-1:0] total_eff;
    logic [TOTAL_W-1:0] left;
    logic [7:0]         count_raw;
    logic [7:0]         count;
    logic               bpp4;
    logic               last_byte;
    logic               emits;
    logic [7:0]         reps;
    logic [TOTAL_W:0]   sum;
    logic               image_end;

    // A total of zero is treated as a one-pixel image
    assign total_eff = (cfg.total_pixels == '0) ? TOTAL_W'(1) : cfg.total_pixels;
    assign bpp4      = (cfg.channels == CHAN_BGRA);

    // Header decoding: run or raw count, clipped to what is left of the image
    always_comb
    begin
        left = (total_eff > done_cnt_reg) ? (total_eff - done_cnt_reg) : TOTAL_W'(1);
        if (byte_data[RUN_FLAG_BIT])
            count_raw = byte_data - RUN_BIAS;
        else
            count_raw = byte_data + 8'd1;
        count = ({{(TOTAL_W-8){1'b0}}, count_raw} > left) ? left[7:0] : count_raw;
    end

    // Pixel byte handling; the last byte of a pixel gives a result
    assign last_byte = bpp4 ? (idx_reg == 2'd3) : (idx_reg >= 2'd2);
    assign emits     = (phase_reg == PH_PIXEL) && last_byte;
    assign byte_take = byte_valid && (!emits || !res_valid_reg || res_ready);

    always_comb
    begin
        reps = run_reg ? remain_reg : 8'd1;
        if (reps == 8'd0)
            reps = 8'd1;
        sum       = {1'b0, done_cnt_reg} + {{(TOTAL_W-7){1'b0}}, reps};
        image_end = (sum >= {1'b0, total_eff});
    end

    // Next state for one accepted byte
    always_comb
    begin
        phase_next    = phase_reg;
        remain_next   = remain_reg;
        run_next      = run_reg;
        idx_next      = idx_reg;
        done_cnt_next = done_cnt_reg;
        for (int i = 0; i < 3; i++)
        begin
            colour_next[i] = colour_reg[i];
        end

        unique case (phase_reg)
            PH_HEADER:
            begin
                run_next    = byte_data[RUN_FLAG_BIT];
                remain_next = count;
                idx_next    = 2'd0;
                phase_next  = PH_PIXEL;
            end
            PH_PIXEL:
            begin
                if (idx_reg != 2'd3)
                    colour_next[idx_reg] = byte_data;
                if (!last_byte)
                begin
                    idx_next = idx_reg + 2'd1;
                end
                else
                begin
                    idx_next = 2'd0;
                    if (image_end)
                    begin
                        done_cnt_next = '0;
                        remain_next   = 8'd0;
                        phase_next    = PH_HEADER;
                    end
                    else
                    begin
                        done_cnt_next = sum[TOTAL_W-1:0];
                        if (run_reg || remain_reg <= 8'd1)
                        begin
                            remain_next = 8'd0;
                            phase_next  = PH_HEADER;
                        end
                        else
                        begin
                            remain_next = remain_reg - 8'd1;
                        end
                    end
                end
            end
            default:
            begin
                phase_next = PH_HEADER;
            end
        endcase
    end

    // Pixel leaves as RGB(A) from bytes that arrived as BGR(A)
    always_comb
    begin
        res_next.red        = colour_next[2];
        res_next.green      = colour_next[1];
        res_next.blue       = colour_next[0];
        res_next.alpha      = bpp4 ? byte_data : 8'd0;
        res_next.repeat_res = reps;
        res_next.image_done = image_end;
    end

    // State and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HEADER;
            remain_reg    <= 8'd0;
            run_reg       <= 1'b0;
            idx_reg       <= 2'd0;
            done_cnt_reg  <= '0;
            res_valid_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                colour_reg[i] <= '0;
            end
        end
        else
        begin
            if (byte_take)
            begin
                phase_reg    <= phase_next;
                remain_reg   <= remain_next;
                run_reg      <= run_next;
                idx_reg      <= idx_next;
                done_cnt_reg <= done_cnt_next;
                for (int i = 0; i < 3; i++)
                begin
                    colour_reg[i] <= colour_next[i];
                end
            end
            if (byte_take && emits)
                res_valid_reg <= 1'b1;
            else if (res_ready)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_take && emits)
            res_reg <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // A waiting pixel is never overwritten by a new one
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        !(byte_take && emits && res_valid_reg && !res_ready))
        else $error("pending pixel overwritten");

    // While reading pixel bytes the packet always has a pixel left
    a_remain_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_PIXEL) |-> (remain_reg != 8'd0))
        else $error("pixel phase with empty packet");

    // Finishing the image restarts the count and awaits a header
    a_image_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (byte_take && emits && image_end) |=>
            (done_cnt_reg == '0) && (phase_reg == PH_HEADER) && res_valid_reg)
        else $error("image end did not restart decoding");

    // A header byte never produces a pixel
    a_header_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (byte_take && (phase_reg == PH_HEADER) && !res_valid_reg) |=> !res_valid_reg)
        else $error("pixel produced from header byte");

endmodule

`default_nettype wire
